/* rtl/core/gss_pkg.sv */
// Shared types, codes and constants for the grid step sequencer.
`default_nettype none

package gss_pkg;

    // Fixed field widths
    localparam int POT_W     = 12;
    localparam int JOY_W     = 12;
    localparam int BPM_W     = 10;
    localparam int TICK_W    = 8;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 4;
    localparam int KIND_W    = 2;
    localparam int INDEX_W   = 4;
    localparam int DATA_W    = 8;
    localparam int ELAPSED_W = 14;
    localparam int STEPMS_W  = 14;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_JOY_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JOY_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BPM_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BPM_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS  = 3'd4;

    localparam logic [JOY_W-1:0]  JOY_HIGH_RST = 12'd3000;
    localparam logic [JOY_W-1:0]  JOY_LOW_RST  = 12'd1000;
    localparam logic [BPM_W-1:0]  BPM_MIN_RST  = 10'd60;
    localparam logic [BPM_W-1:0]  BPM_MAX_RST  = 10'd180;
    localparam logic [TICK_W-1:0] TICK_MS_RST  = 8'd10;

    // Grid geometry defaults
    localparam int STEPS_DEF = 16;
    localparam int ROWS_DEF  = 8;

    // Shared divider: two quotient bits per cycle
    localparam int DIV_W     = 22;
    localparam int DSR_W     = 12;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [DIV_W-1:0] MS_PER_MIN = 22'd60000;
    localparam logic [DSR_W-1:0] POT_FULL   = 12'd4095;
    localparam logic [DSR_W-1:0] ON_DEN     = 12'd3;

    // Item operation codes
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_CURSOR   = 2'd0,
        KIND_COLUMN   = 2'd1,
        KIND_NOTE_ON  = 2'd2,
        KIND_NOTE_OFF = 2'd3
    } t_msg_kind;

    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_RIGHT = 3'd1,
        DIR_LEFT  = 3'd2,
        DIR_UP    = 3'd3,
        DIR_DOWN  = 3'd4
    } t_dir;

    typedef enum logic [1:0] {
        SCAN_START  = 2'd0,
        SCAN_IDLE   = 2'd1,
        SCAN_MOVE   = 2'd2,
        SCAN_UNUSED = 2'd3
    } t_scan_phase;

    typedef enum logic [1:0] {
        SEQ_START  = 2'd0,
        SEQ_ON     = 2'd1,
        SEQ_OFF    = 2'd2,
        SEQ_UNUSED = 2'd3
    } t_seq_phase;

    typedef enum logic [1:0] {
        DIV_TEMPO = 2'd0,
        DIV_STEP  = 2'd1,
        DIV_ON    = 2'd2
    } t_div_sel;

    typedef enum logic [1:0] {
        EMIT_CURSOR = 2'd0,
        EMIT_COLUMN = 2'd1,
        EMIT_NOTE   = 2'd2
    } t_emit_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TEMPO_GO,
        ST_TEMPO_WAIT,
        ST_CUR_MSG,
        ST_COL_MSG,
        ST_TICK_GO,
        ST_STEP_WAIT,
        ST_ON_GO,
        ST_ON_WAIT,
        ST_NOTE_MSG
    } t_state;

    typedef struct packed {
        logic      load;
        logic      scan_upd;
        logic      div_start;
        t_div_sel  div_sel;
        logic      tempo_set;
        logic      step_set;
        logic      tick_upd;
        logic      emit;
        t_emit_sel emit_sel;
        logic      emit_last;
    } t_cmd;

    typedef struct packed {
        logic act;
        logic div_busy;
        logic cur_pend;
        logic col_pend;
        logic note_pend;
        logic slot_free;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/core/gss_div.sv */
// Iterative restoring divider, two quotient bits per cycle.
`default_nettype none

module gss_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [gss_pkg::DIV_W-1:0] i_dividend,
    input  wire logic [gss_pkg::DSR_W-1:0] i_divisor,
    output logic                           o_busy,
    output logic [gss_pkg::DIV_W-1:0]      o_quotient
);
    import gss_pkg::*;

    logic [DSR_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_quo, n_quo;
    logic [DSR_W-1:0]  r_dsr;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;

    always_comb begin
        logic [DSR_W:0] sh;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            sh = {n_rem, n_quo[DIV_W-1]};
            if (sh >= {1'b0, r_dsr}) begin
                sh = sh - {1'b0, r_dsr};
                n_quo = {n_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_quo = {n_quo[DIV_W-2:0], 1'b0};
            end
            n_rem = sh[DSR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DCNT_W'(DIV_STEPS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* rtl/core/gss_datapath.sv */
// Datapath: config registers, cursor and grid state, tempo, playback timing, output beat.
`default_nettype none

module gss_datapath #(
    parameter int STEPS = gss_pkg::STEPS_DEF,
    parameter int ROWS  = gss_pkg::ROWS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [gss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [gss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_operation,
    input  wire logic [gss_pkg::POT_W-1:0]      i_pot_level,
    input  wire logic [gss_pkg::JOY_W-1:0]      i_joy_x,
    input  wire logic [gss_pkg::JOY_W-1:0]      i_joy_y,
    input  wire logic                           i_button_level,
    input  wire gss_pkg::t_cmd                  i_cmd,
    output gss_pkg::t_sts                       o_sts,
    input  wire logic                           i_out_stall,
    output logic                                o_out_valid,
    output logic [gss_pkg::KIND_W-1:0]          o_msg_kind,
    output logic [gss_pkg::INDEX_W-1:0]         o_msg_index,
    output logic [gss_pkg::DATA_W-1:0]          o_msg_data,
    output logic                                o_last_msg
);
    import gss_pkg::*;

    // Configuration
    logic [JOY_W-1:0]  r_joy_high, r_joy_low;
    logic [BPM_W-1:0]  r_bpm_min, r_bpm_max;
    logic [TICK_W-1:0] r_tick_ms;

    // Captured item
    logic             r_op;
    logic [POT_W-1:0] r_pot;
    logic [JOY_W-1:0] r_x, r_y;
    logic             r_btn;

    // Editing state
    t_scan_phase      r_scan_phase, n_scan_phase;
    logic             r_prev_btn;
    t_dir             r_last_dir, scan_dir;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [STEPS-1:0] r_grid [ROWS];
    logic [COL_W-1:0] r_col_idx;
    logic             r_cur_pend, r_col_pend, r_note_pend;
    logic             scan_act, scan_move, scan_press;
    logic [DIV_W-1:0] r_prod;
    logic [BPM_W-1:0] span;

    // Tempo and playback
    logic [BPM_W-1:0]     r_tempo, n_tempo, tempo_eff;
    logic [BPM_W:0]       tempo_sum;
    t_seq_phase           r_seq_phase, n_seq_phase;
    logic [COL_W-1:0]     r_play_step, n_play_step;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [ELAPSED_W:0]   elapsed_sum;
    logic [STEPMS_W-1:0]  r_step_ms, on_ms, off_ms;
    logic                 tick_fire;
    t_msg_kind            r_note_kind;

    // Divider
    logic [DIV_W-1:0] div_dividend, div_quo;
    logic [DSR_W-1:0] div_divisor;
    logic             div_busy;

    // Output beat
    logic                r_out_valid;
    t_msg_kind           r_kind;
    logic [INDEX_W-1:0]  r_index;
    logic [DATA_W-1:0]   r_data;
    logic                r_last;
    logic [COL_W-1:0]    mask_addr;
    logic [DATA_W-1:0]   col_mask;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joy_high <= JOY_HIGH_RST;
            r_joy_low  <= JOY_LOW_RST;
            r_bpm_min  <= BPM_MIN_RST;
            r_bpm_max  <= BPM_MAX_RST;
            r_tick_ms  <= TICK_MS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_JOY_HIGH: r_joy_high <= i_cfg_data[JOY_W-1:0];
                CFG_JOY_LOW:  r_joy_low  <= i_cfg_data[JOY_W-1:0];
                CFG_BPM_MIN:  r_bpm_min  <= i_cfg_data[BPM_W-1:0];
                CFG_BPM_MAX:  r_bpm_max  <= i_cfg_data[BPM_W-1:0];
                CFG_TICK_MS:  r_tick_ms  <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_pot <= i_pot_level;
            r_x   <= i_joy_x;
            r_y   <= i_joy_y;
            r_btn <= i_button_level;
        end
    end

    // ---------------- scan logic ----------------
    always_comb begin
        if (r_x > r_joy_high) begin
            scan_dir = DIR_RIGHT;
        end else if (r_x < r_joy_low) begin
            scan_dir = DIR_LEFT;
        end else if (r_y > r_joy_high) begin
            scan_dir = DIR_UP;
        end else if (r_y < r_joy_low) begin
            scan_dir = DIR_DOWN;
        end else begin
            scan_dir = DIR_NONE;
        end

        scan_act     = 1'b1;
        n_scan_phase = r_scan_phase;
        unique case (r_scan_phase)
            SCAN_START: n_scan_phase = SCAN_IDLE;
            SCAN_IDLE: begin
                if (scan_dir != DIR_NONE) n_scan_phase = SCAN_MOVE;
            end
            SCAN_MOVE: begin
                if (scan_dir == DIR_NONE) n_scan_phase = SCAN_IDLE;
            end
            SCAN_UNUSED: begin
                n_scan_phase = SCAN_START;
                scan_act     = 1'b0;
            end
            default: n_scan_phase = SCAN_START;
        endcase

        scan_move = scan_act && (n_scan_phase == SCAN_MOVE) && (scan_dir != r_last_dir);

        n_row = r_row;
        n_col = r_col;
        if (scan_move) begin
            case (scan_dir)
                DIR_RIGHT: n_col = ({1'b0, r_col} + 1'b1 == (COL_W+1)'(STEPS)) ? '0
                                                                            : r_col + 1'b1;
                DIR_LEFT:  n_col = (r_col == '0) ? COL_W'(STEPS - 1) : r_col - 1'b1;
                DIR_UP:    n_row = (r_row == '0) ? ROW_W'(ROWS - 1) : r_row - 1'b1;
                DIR_DOWN:  n_row = ({1'b0, r_row} + 1'b1 == (ROW_W+1)'(ROWS)) ? '0
                                                                           : r_row + 1'b1;
                default: ;
            endcase
        end

        scan_press = !r_btn && r_prev_btn;
        span       = (r_bpm_max >= r_bpm_min) ? (r_bpm_max - r_bpm_min) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_phase <= SCAN_START;
            r_prev_btn   <= 1'b1;
            r_last_dir   <= DIR_NONE;
            r_row        <= '0;
            r_col        <= '0;
            r_cur_pend   <= 1'b0;
            r_col_pend   <= 1'b0;
        end else if (i_cmd.load) begin
            r_cur_pend <= 1'b0;
            r_col_pend <= 1'b0;
        end else if (i_cmd.scan_upd) begin
            r_scan_phase <= n_scan_phase;
            r_prev_btn   <= r_btn;
            r_last_dir   <= scan_dir;
            r_row        <= n_row;
            r_col        <= n_col;
            r_cur_pend   <= scan_move;
            r_col_pend   <= scan_press;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_upd) begin
            r_col_idx <= n_col;
            r_prod    <= {{(DIV_W-POT_W){1'b0}}, r_pot} * {{(DIV_W-BPM_W){1'b0}}, span};
        end
    end

    // Grid: one toggle per button press, at the cursor after this scan's move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) r_grid[r] <= '0;
        end else if (i_cmd.scan_upd && scan_press) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < STEPS; c++) begin
                    if (ROW_W'(r) == n_row && COL_W'(c) == n_col) begin
                        r_grid[r][c] <= ~r_grid[r][c];
                    end
                end
            end
        end
    end

    // Row mask of one column
    assign mask_addr = (i_cmd.emit_sel == EMIT_COLUMN) ? r_col_idx : r_play_step;

    always_comb begin
        col_mask = '0;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < STEPS; c++) begin
                if (COL_W'(c) == mask_addr) col_mask[r] = r_grid[r][c];
            end
        end
    end

    // ---------------- divider ----------------
    assign tempo_eff = (r_tempo == '0) ? BPM_W'(1) : r_tempo;

    always_comb begin
        case (i_cmd.div_sel)
            DIV_TEMPO: begin
                div_dividend = r_prod;
                div_divisor  = POT_FULL;
            end
            DIV_STEP: begin
                div_dividend = MS_PER_MIN;
                div_divisor  = {{(DSR_W-BPM_W){1'b0}}, tempo_eff};
            end
            default: begin
                div_dividend = {{(DIV_W-STEPMS_W-1){1'b0}}, r_step_ms, 1'b0};
                div_divisor  = ON_DEN;
            end
        endcase
    end

    gss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    // ---------------- tempo ----------------
    always_comb begin
        tempo_sum = {1'b0, r_bpm_min} + {1'b0, div_quo[BPM_W-1:0]};
        n_tempo   = (tempo_sum == '0) ? BPM_W'(1) : tempo_sum[BPM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tempo <= BPM_MIN_RST;
        end else if (i_cmd.tempo_set) begin
            r_tempo <= n_tempo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step_set) r_step_ms <= div_quo[STEPMS_W+1:2];
    end

    // ---------------- playback ----------------
    always_comb begin
        on_ms       = div_quo[STEPMS_W-1:0];
        off_ms      = r_step_ms - on_ms;
        elapsed_sum = {1'b0, r_elapsed} + {{(ELAPSED_W+1-TICK_W){1'b0}}, r_tick_ms};

        n_seq_phase = r_seq_phase;
        n_elapsed   = r_elapsed;
        n_play_step = r_play_step;
        tick_fire   = 1'b0;
        unique case (r_seq_phase)
            SEQ_START: begin
                n_seq_phase = SEQ_ON;
                n_elapsed   = '0;
                tick_fire   = 1'b1;
            end
            SEQ_ON: begin
                if (elapsed_sum >= {1'b0, on_ms}) begin
                    n_elapsed   = '0;
                    n_seq_phase = SEQ_OFF;
                    tick_fire   = 1'b1;
                end else begin
                    n_elapsed = elapsed_sum[ELAPSED_W-1:0];
                end
            end
            SEQ_OFF: begin
                if (elapsed_sum >= {1'b0, off_ms}) begin
                    n_elapsed   = '0;
                    n_seq_phase = SEQ_ON;
                    tick_fire   = 1'b1;
                    n_play_step = ({1'b0, r_play_step} + 1'b1 == (COL_W+1)'(STEPS)) ? '0
                                                                      : r_play_step + 1'b1;
                end else begin
                    n_elapsed = elapsed_sum[ELAPSED_W-1:0];
                end
            end
            SEQ_UNUSED: n_seq_phase = SEQ_START;
            default:    n_seq_phase = SEQ_START;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_phase <= SEQ_START;
            r_elapsed   <= '0;
            r_play_step <= '0;
            r_note_pend <= 1'b0;
        end else if (i_cmd.load) begin
            r_note_pend <= 1'b0;
        end else if (i_cmd.tick_upd) begin
            r_seq_phase <= n_seq_phase;
            r_elapsed   <= n_elapsed;
            r_play_step <= n_play_step;
            r_note_pend <= tick_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_upd) begin
            r_note_kind <= (n_seq_phase == SEQ_ON) ? KIND_NOTE_ON : KIND_NOTE_OFF;
        end
    end

    // ---------------- output beat ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_last <= i_cmd.emit_last;
            case (i_cmd.emit_sel)
                EMIT_CURSOR: begin
                    r_kind  <= KIND_CURSOR;
                    r_index <= {{(INDEX_W-ROW_W){1'b0}}, r_row};
                    r_data  <= {{(DATA_W-COL_W){1'b0}}, r_col};
                end
                EMIT_COLUMN: begin
                    r_kind  <= KIND_COLUMN;
                    r_index <= r_col_idx;
                    r_data  <= col_mask;
                end
                default: begin
                    r_kind <= r_note_kind;
                    if (r_note_kind == KIND_NOTE_ON) begin
                        r_index <= r_play_step;
                        r_data  <= col_mask;
                    end else begin
                        r_index <= '0;
                        r_data  <= '0;
                    end
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_msg_kind  = r_kind;
    assign o_msg_index = r_index;
    assign o_msg_data  = r_data;
    assign o_last_msg  = r_last;

    // Status to the controller
    always_comb begin
        o_sts.act       = (r_scan_phase != SCAN_UNUSED) && (r_op == OP_SCAN);
        o_sts.div_busy  = div_busy;
        o_sts.cur_pend  = r_cur_pend;
        o_sts.col_pend  = r_col_pend;
        o_sts.note_pend = r_note_pend;
        o_sts.slot_free = !r_out_valid || !i_out_stall;
    end

endmodule

`default_nettype wire

/* rtl/core/gss_ctrl.sv */
// Controller state machine: sequences scan and tick items through the datapath.
`default_nettype none

module gss_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_operation,
    output logic               o_in_stall,
    input  wire gss_pkg::t_sts i_sts,
    output gss_pkg::t_cmd      o_cmd
);
    import gss_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_operation == OP_TICK) ? ST_TICK_GO : ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_upd = 1'b1;
                n_state        = i_sts.act ? ST_TEMPO_GO : ST_CUR_MSG;
            end
            ST_TEMPO_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_TEMPO;
                n_state         = ST_TEMPO_WAIT;
            end
            ST_TEMPO_WAIT: begin
                o_cmd.div_sel = DIV_TEMPO;
                if (!i_sts.div_busy) begin
                    o_cmd.tempo_set = 1'b1;
                    n_state         = ST_CUR_MSG;
                end
            end
            ST_CUR_MSG: begin
                o_cmd.emit_sel = EMIT_CURSOR;
                if (!i_sts.cur_pend) begin
                    n_state = ST_COL_MSG;
                end else if (i_sts.slot_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = !i_sts.col_pend;
                    n_state         = i_sts.col_pend ? ST_COL_MSG : ST_IDLE;
                end
            end
            ST_COL_MSG: begin
                o_cmd.emit_sel = EMIT_COLUMN;
                if (!i_sts.col_pend) begin
                    n_state = ST_IDLE;
                end else if (i_sts.slot_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            ST_TICK_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_STEP;
                n_state         = ST_STEP_WAIT;
            end
            ST_STEP_WAIT: begin
                o_cmd.div_sel = DIV_STEP;
                if (!i_sts.div_busy) begin
                    o_cmd.step_set = 1'b1;
                    n_state        = ST_ON_GO;
                end
            end
            ST_ON_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_ON;
                n_state         = ST_ON_WAIT;
            end
            ST_ON_WAIT: begin
                o_cmd.div_sel = DIV_ON;
                if (!i_sts.div_busy) begin
                    o_cmd.tick_upd = 1'b1;
                    n_state        = ST_NOTE_MSG;
                end
            end
            ST_NOTE_MSG: begin
                o_cmd.emit_sel = EMIT_NOTE;
                if (!i_sts.note_pend) begin
                    n_state = ST_IDLE;
                end else if (i_sts.slot_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/grid_step_sequencer_top.sv */
// Grid step sequencer: note grid editor with a tempo-driven playback sequencer.
//
// Input channel (i_in_valid / o_in_stall): one beat per item. Operation 0 is a
// scan carrying pot, joystick and button samples; operation 1 is a playback tick.
// Output channel (o_out_valid / i_out_stall): up to two message beats per item,
// o_last_msg marks the final beat of an item. An item with no message leaves
// nothing on the output.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_index (0 joy_high,
// 1 joy_low, 2 bpm_min, 3 bpm_max, 4 tick_ms); unknown indexes are dropped.
// Timing: items are handled one at a time. Scans and ticks wait on the shared
// 22-bit divider, which retires two quotient bits a cycle: one divide for a
// scan's tempo, two for a tick's note lengths. The next item is accepted the
// cycle after an item's last message is loaded.
// o_in_stall stays high until the item's last message is loaded in the output
// register, so a stalled receiver holds off the next item at that point.
// Reset (synchronous, active low) clears the grid, cursor, playback position
// and restores the register defaults; no clearing pass is needed.
`default_nettype none

module grid_step_sequencer_top #(
    parameter int STEPS = gss_pkg::STEPS_DEF,
    parameter int ROWS  = gss_pkg::ROWS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [gss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [gss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_operation,
    input  wire logic [gss_pkg::POT_W-1:0]      i_pot_level,
    input  wire logic [gss_pkg::JOY_W-1:0]      i_joy_x,
    input  wire logic [gss_pkg::JOY_W-1:0]      i_joy_y,
    input  wire logic                           i_button_level,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [gss_pkg::KIND_W-1:0]          o_msg_kind,
    output logic [gss_pkg::INDEX_W-1:0]         o_msg_index,
    output logic [gss_pkg::DATA_W-1:0]          o_msg_data,
    output logic                                o_last_msg
);
    import gss_pkg::*;

    t_cmd cmd;
    t_sts sts;

    gss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_stall  (o_in_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gss_datapath #(
        .STEPS (STEPS),
        .ROWS  (ROWS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (i_operation),
        .i_pot_level    (i_pot_level),
        .i_joy_x        (i_joy_x),
        .i_joy_y        (i_joy_y),
        .i_button_level (i_button_level),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_msg_kind     (o_msg_kind),
        .o_msg_index    (o_msg_index),
        .o_msg_data     (o_msg_data),
        .o_last_msg     (o_last_msg)
    );

endmodule

`default_nettype wire

/* verif/gss_checker.sv */
// Grid step sequencer checker: watches both channels, predicts messages and compares them.
`timescale 1ns / 100ps

module gss_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_operation,
    input  logic [gss_pkg::POT_W-1:0]      i_pot_level,
    input  logic [gss_pkg::JOY_W-1:0]      i_joy_x,
    input  logic [gss_pkg::JOY_W-1:0]      i_joy_y,
    input  logic                           i_button_level,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [gss_pkg::KIND_W-1:0]     i_msg_kind,
    input  logic [gss_pkg::INDEX_W-1:0]    i_msg_index,
    input  logic [gss_pkg::DATA_W-1:0]     i_msg_data,
    input  logic                           i_last_msg,
    output int                             o_mismatches,
    output int                             o_pending
);
    import gss_pkg::*;

    localparam int STEPS = STEPS_DEF;
    localparam int ROWS  = ROWS_DEF;

    typedef struct packed {
        t_msg_kind          kind;
        logic [INDEX_W-1:0] index;
        logic [DATA_W-1:0]  data;
        logic               last;
    } t_note_msg;

    t_note_msg expected_msgs [$];
    int        mismatches;

    // register copies
    logic [JOY_W-1:0]  thr_high, thr_low;
    logic [BPM_W-1:0]  bpm_lo, bpm_hi;
    logic [TICK_W-1:0] tick_len;

    // sequencer state
    t_scan_phase         scan_ph;
    logic                last_btn;
    t_dir                dir_prev;
    logic [ROW_W-1:0]    cur_row;
    logic [COL_W-1:0]    cur_col;
    logic [STEPS-1:0]    grid [ROWS];
    logic [BPM_W-1:0]    tempo;
    t_seq_phase          seq_ph;
    logic [INDEX_W-1:0]  step_pos;
    logic [ELAPSED_W-1:0] elapsed;

    function automatic logic [DATA_W-1:0] rows_at(input int col);
        logic [DATA_W-1:0] mask;
        mask = '0;
        for (int r = 0; r < ROWS; r++)
            if (grid[r][col])
                mask[r] = 1'b1;
        return mask;
    endfunction

    task automatic predict_item(input logic op, input logic [POT_W-1:0] pot,
                                input logic [JOY_W-1:0] x, y, input logic btn);
        t_note_msg   batch [2];
        int          n;
        t_dir        dir;
        logic        live;
        logic        fire;
        int unsigned span, bpm, rate, step_ms, on_ms, off_ms, sum;
        n = 0;
        if (op == OP_SCAN) begin
            dir = DIR_NONE;
            if (x > thr_high)      dir = DIR_RIGHT;
            else if (x < thr_low)  dir = DIR_LEFT;
            else if (y > thr_high) dir = DIR_UP;
            else if (y < thr_low)  dir = DIR_DOWN;

            live = 1'b1;
            case (scan_ph)
                SCAN_START: scan_ph = SCAN_IDLE;
                SCAN_IDLE: begin
                    if (dir != DIR_NONE) scan_ph = SCAN_MOVE;
                end
                SCAN_MOVE: begin
                    if (dir == DIR_NONE) scan_ph = SCAN_IDLE;
                end
                default: begin
                    scan_ph = SCAN_START;
                    live = 1'b0;
                end
            endcase

            if (live) begin
                if (bpm_hi >= bpm_lo) span = bpm_hi - bpm_lo;
                else span = 0;
                bpm = bpm_lo + (pot * span) / POT_FULL;
                if (bpm == 0) bpm = 1;
                tempo = BPM_W'(bpm);
                if (scan_ph == SCAN_MOVE && dir != dir_prev) begin
                    case (dir)
                        DIR_RIGHT: cur_col = COL_W'((cur_col + 1) % STEPS);
                        DIR_LEFT:  cur_col = (cur_col == 0) ? COL_W'(STEPS - 1) : cur_col - 1'b1;
                        DIR_UP:    cur_row = (cur_row == 0) ? ROW_W'(ROWS - 1) : cur_row - 1'b1;
                        DIR_DOWN:  cur_row = ROW_W'((cur_row + 1) % ROWS);
                        default: ;
                    endcase
                    batch[n] = '{KIND_CURSOR, INDEX_W'(cur_row), DATA_W'(cur_col), 1'b0};
                    n++;
                end
            end

            // press edge flips the cell under the cursor
            if (!btn && last_btn) begin
                grid[cur_row][cur_col] = ~grid[cur_row][cur_col];
                batch[n] = '{KIND_COLUMN, INDEX_W'(cur_col), rows_at(cur_col), 1'b0};
                n++;
            end
            last_btn = btn;
            dir_prev = dir;
        end else begin
            rate    = (tempo == 0) ? 1 : tempo;
            step_ms = (MS_PER_MIN / rate) / 4;
            on_ms   = step_ms * 2 / 3;
            off_ms  = step_ms - on_ms;
            fire    = 1'b0;
            case (seq_ph)
                SEQ_START: begin
                    seq_ph  = SEQ_ON;
                    elapsed = '0;
                    fire    = 1'b1;
                end
                SEQ_ON: begin
                    sum = elapsed + tick_len;
                    if (sum >= on_ms) begin
                        sum    = 0;
                        fire   = 1'b1;
                        seq_ph = SEQ_OFF;
                    end
                    elapsed = ELAPSED_W'(sum);
                end
                SEQ_OFF: begin
                    sum = elapsed + tick_len;
                    if (sum >= off_ms) begin
                        sum      = 0;
                        fire     = 1'b1;
                        step_pos = INDEX_W'((step_pos + 1) % STEPS);
                        seq_ph   = SEQ_ON;
                    end
                    elapsed = ELAPSED_W'(sum);
                end
                default: seq_ph = SEQ_START;
            endcase
            if (fire) begin
                if (seq_ph == SEQ_ON) begin
                    batch[n] = '{KIND_NOTE_ON, step_pos, rows_at(step_pos), 1'b0};
                    n++;
                end else if (seq_ph == SEQ_OFF) begin
                    batch[n] = '{KIND_NOTE_OFF, '0, '0, 1'b0};
                    n++;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            batch[i].last = (i == n - 1);
            expected_msgs.push_back(batch[i]);
        end
    endtask

    task automatic flag(input string what, input int want, input int got);
        mismatches++;
        $display("%0t gss_checker: %s expected %0d got %0d", $time, what, want, got);
    endtask

    task automatic check_beat();
        t_note_msg want;
        if (expected_msgs.size() == 0) begin
            mismatches++;
            $display("%0t gss_checker: message expected none got kind %0d index %0d",
                     $time, i_msg_kind, i_msg_index,
                     " data %0d last %0b", i_msg_data, i_last_msg);
        end else begin
            want = expected_msgs.pop_front();
            if (want.kind != i_msg_kind)   flag("msg_kind", want.kind, i_msg_kind);
            if (want.index != i_msg_index) flag("msg_index", want.index, i_msg_index);
            if (want.data != i_msg_data)   flag("msg_data", want.data, i_msg_data);
            if (want.last != i_last_msg)   flag("last_msg", want.last, i_last_msg);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr_high = JOY_HIGH_RST;
            thr_low  = JOY_LOW_RST;
            bpm_lo   = BPM_MIN_RST;
            bpm_hi   = BPM_MAX_RST;
            tick_len = TICK_MS_RST;
            scan_ph  = SCAN_START;
            last_btn = 1'b1;
            dir_prev = DIR_NONE;
            cur_row  = '0;
            cur_col  = '0;
            for (int r = 0; r < ROWS; r++)
                grid[r] = '0;
            tempo    = BPM_MIN_RST;
            seq_ph   = SEQ_START;
            step_pos = '0;
            elapsed  = '0;
            mismatches = 0;
            expected_msgs.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_JOY_HIGH: thr_high = i_cfg_data[JOY_W-1:0];
                    CFG_JOY_LOW:  thr_low  = i_cfg_data[JOY_W-1:0];
                    CFG_BPM_MIN:  bpm_lo   = i_cfg_data[BPM_W-1:0];
                    CFG_BPM_MAX:  bpm_hi   = i_cfg_data[BPM_W-1:0];
                    CFG_TICK_MS:  tick_len = i_cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall)
                check_beat();
            if (i_in_valid && !i_in_stall)
                predict_item(i_operation, i_pot_level, i_joy_x, i_joy_y, i_button_level);
        end
        o_pending    <= expected_msgs.size();
        o_mismatches <= mismatches;
    end

endmodule

/* verif/tb_grid_step_sequencer_top.sv */
// Testbench top for the grid step sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_grid_step_sequencer_top;
    import gss_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 64;
    localparam logic [JOY_W-1:0] JOY_MID = 12'd2000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_TICK_MS + 1'b1;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  operation;
    logic [POT_W-1:0]      pot;
    logic [JOY_W-1:0]      joy_x, joy_y;
    logic                  button;
    logic                  out_valid;
    logic                  out_stall;
    logic [KIND_W-1:0]     msg_kind;
    logic [INDEX_W-1:0]    msg_index;
    logic [DATA_W-1:0]     msg_data;
    logic                  last_msg;
    int                    mismatches;
    int                    pending;
    int                    cycles = 0;

    logic             tx_quiet;
    logic             rx_quiet;
    logic             btn_level;
    logic [JOY_W-1:0] cur_high, cur_low;

    grid_step_sequencer_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_operation    (operation),
        .i_pot_level    (pot),
        .i_joy_x        (joy_x),
        .i_joy_y        (joy_y),
        .i_button_level (button),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_msg_kind     (msg_kind),
        .o_msg_index    (msg_index),
        .o_msg_data     (msg_data),
        .o_last_msg     (last_msg)
    );

    gss_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_operation    (operation),
        .i_pot_level    (pot),
        .i_joy_x        (joy_x),
        .i_joy_y        (joy_y),
        .i_button_level (button),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_msg_kind     (msg_kind),
        .i_msg_index    (msg_index),
        .i_msg_data     (msg_data),
        .i_last_msg     (last_msg),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_grid_step_sequencer_top: done, errors");
            $finish;
        end
    end

    // Receiver: draws a stall length for each message beat.
    initial begin
        int unsigned hold;
        int          beats;
        out_stall = 1'b0;
        rx_quiet  = 1'b0;
        hold      = 0;
        beats     = 0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                out_stall <= 1'b1;
                hold--;
            end else begin
                out_stall <= 1'b0;
            end
            @(posedge clk);
            if (out_valid && !out_stall) begin
                beats++;
                if (beats % 32 == 0)
                    rx_quiet = ($urandom_range(0, 2) == 0);
                hold = rx_quiet ? 0 : $urandom_range(0, 18);
            end
        end
    end

    // Entered and left at a falling edge; valid stays up after the beat so a
    // back-to-back item needs no second assignment in one step.
    task automatic push_item(input logic op, input logic [JOY_W-1:0] pot_v, x_v, y_v,
                             input logic btn_v);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        pot       <= pot_v;
        joy_x     <= x_v;
        joy_y     <= y_v;
        button    <= btn_v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic scan(input logic [POT_W-1:0] pot_v, input logic [JOY_W-1:0] x_v, y_v,
                        input logic btn_v);
        push_item(OP_SCAN, pot_v, x_v, y_v, btn_v);
    endtask

    task automatic tick();
        push_item(OP_TICK, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                  12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
    endtask

    // Wait out all expected messages plus the latency of a silent item.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [JOY_W-1:0] joy_pick();
        logic [JOY_W-1:0] v;
        case ($urandom_range(0, 6))
            0, 1, 2: v = 12'($urandom_range(cur_low, cur_high));
            3:       v = 12'($urandom_range(cur_high, 4095));
            4:       v = 12'($urandom_range(0, cur_low));
            5:       v = 12'($urandom_range(0, 4095));
            default: begin
                // threshold edges: equal is not past, one step beyond is
                case ($urandom_range(0, 3))
                    0:       v = cur_high;
                    1:       v = cur_high + 1'b1;
                    2:       v = cur_low;
                    default: v = cur_low - 1'b1;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic run_phase(input logic [JOY_W-1:0] high, low,
                             input logic [BPM_W-1:0] bmin, bmax,
                             input logic [TICK_W-1:0] tick_len, input int count);
        logic [JOY_W-1:0] x, y;
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_JOY_HIGH;
        cfg_data  <= high;
        @(negedge clk);
        cfg_index <= CFG_JOY_LOW;
        cfg_data  <= low;
        @(negedge clk);
        // upper data bits are junk for the narrow registers
        cfg_index <= CFG_BPM_MIN;
        cfg_data  <= {2'($urandom_range(0, 3)), bmin};
        @(negedge clk);
        cfg_index <= CFG_BPM_MAX;
        cfg_data  <= {2'($urandom_range(0, 3)), bmax};
        @(negedge clk);
        cfg_index <= CFG_TICK_MS;
        cfg_data  <= {4'($urandom_range(0, 15)), tick_len};
        @(negedge clk);
        cfg_index <= CFG_SPARE + 3'($urandom_range(0, 2));
        cfg_data  <= 12'($urandom_range(0, 4095));
        @(negedge clk);
        cfg_we   <= 1'b0;
        cur_high = high;
        cur_low  = low;

        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0)
                tx_quiet = ($urandom_range(0, 2) == 0);
            if (count > 120 && i == count / 2)
                settle();
            if ($urandom_range(0, 99) < 45) begin
                tick();
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    x = 12'($urandom_range(cur_low, cur_high));
                    y = 12'($urandom_range(cur_low, cur_high));
                end else begin
                    x = joy_pick();
                    y = joy_pick();
                end
                if ($urandom_range(0, 3) == 0)
                    btn_level = ~btn_level;
                scan(12'($urandom_range(0, 4095)), x, y, btn_level);
            end
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        operation = OP_SCAN;
        pot       = '0;
        joy_x     = JOY_MID;
        joy_y     = JOY_MID;
        button    = 1'b1;
        tx_quiet  = 1'b0;
        btn_level = 1'b1;
        cur_high  = JOY_HIGH_RST;
        cur_low   = JOY_LOW_RST;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, reset thresholds
        tick();                                  // playback start: note on, empty column
        scan(12'd0, JOY_MID, JOY_MID, 1'b1);     // first scan moves nothing
        scan(12'd4095, 12'd4095, JOY_MID, 1'b1); // right
        scan(12'd4095, 12'd4095, JOY_MID, 1'b1); // held direction
        scan(12'd4095, JOY_MID, JOY_MID, 1'b0);  // center plus press
        scan(12'd4095, 12'd0, JOY_MID, 1'b0);    // left, button still down
        scan(12'd4095, 12'd4095, 12'd0, 1'b1);   // x wins over y
        scan(12'd4095, JOY_MID, 12'd4095, 1'b1); // up without passing center, row wraps
        scan(12'd4095, JOY_MID, 12'd0, 1'b0);    // down plus press: two beats
        scan(12'd2048, 12'd3000, 12'd1000, 1'b1);// on both thresholds: centered
        scan(12'd2048, 12'd3001, JOY_MID, 1'b0);
        scan(12'd2048, 12'd999, JOY_MID, 1'b1);
        repeat (14) tick();                      // note off, then the next step on

        run_phase(12'd3000, 12'd1000, 10'd60, 10'd180, 8'd10, 250);
        run_phase(12'd4095, 12'd0, 10'd60, 10'd180, 8'd10, 60);
        run_phase(12'd0, 12'd4095, 10'd1, 10'd1000, 8'd255, 80);
        run_phase(12'd3000, 12'd1000, 10'd1000, 10'd1000, 8'd10, 150);
        run_phase(12'd2048, 12'd2047, 10'd0, 10'd0, 8'd255, 80);   // tempo clamps to one
        run_phase(12'd1000, 12'd3000, 10'd500, 10'd100, 8'd0, 60); // inverted range, no advance
        run_phase(12'($urandom_range(2048, 4095)), 12'($urandom_range(0, 2047)),
                  10'd1023, 10'd1023, 8'd1, 100);
        run_phase(12'd3000, 12'd1000, 10'd60, 10'd180, 8'd10, 150);

        settle();
        if (mismatches == 0 && pending == 0)
            $display("tb_grid_step_sequencer_top: done, clean");
        else
            $display("tb_grid_step_sequencer_top: done, errors");
        $finish;
    end

endmodule
